FILE: src/csa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants of the CSR segment aggregator
// Item layouts, field widths, mode and op codes, and default sizes.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam int DATA_W       = 32;
   localparam int ACC_W        = 48;
   localparam int FEAT_W       = 6;
   localparam int MODE_W       = 2;

   localparam int FEATS_DEF    = 8;
   localparam int DEG_BITS_DEF = 16;
   localparam int WORK_DEPTH   = 4;
   localparam int RSP_DEPTH    = 2;

   localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

   localparam logic OP_ELEM  = 1'b0;
   localparam logic OP_EMPTY = 1'b1;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] msg;
      logic [FEAT_W-1:0]        in_feat;
      logic                     last_edge;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic [FEAT_W-1:0]        out_feat;
      logic                     row_done;
   } rsp_type;

   typedef struct packed {
      logic                     clear_row;
      logic signed [DATA_W-1:0] msg;
      logic [FEAT_W-1:0]        feat;
      logic                     last_edge;
   } work_type;

endpackage
`default_nettype wire

FILE: src/csa_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_fifo: small register queue
// Holds items between the front and back parts and in front of the result
// port; push and pop in the same cycle are allowed.
// ----------------------------------------------------------------------------
module csa_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: src/csa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_front: input stage of the segment aggregator
// Accepts request items, drops elements whose feature index is out of
// range, and hands the rest to the work queue as classified work items.
// ----------------------------------------------------------------------------
module csa_front #(
   parameter int FEATS = csa_pkg::FEATS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire csa_pkg::req_type  req_data,
   output logic                   req_full,
   output logic                   work_push,
   output csa_pkg::work_type      work_data,
   input  wire logic              work_full
);

   localparam logic [csa_pkg::FEAT_W:0] FEAT_LIM = (csa_pkg::FEAT_W + 1)'(FEATS);

   logic               stage_vld_ff, stage_vld_in;
   csa_pkg::work_type  stage_ff, stage_in;
   csa_pkg::work_type  classified;
   logic               accept, keep, moved;

   assign req_full  = stage_vld_ff & work_full;
   assign work_push = stage_vld_ff;
   assign work_data = stage_ff;
   assign accept    = req_push & ~req_full;
   assign moved     = stage_vld_ff & ~work_full;
   assign keep      = (req_data.op == csa_pkg::OP_EMPTY) ||
                      ({1'b0, req_data.in_feat} < FEAT_LIM);

   always_comb begin
      classified.clear_row = (req_data.op == csa_pkg::OP_EMPTY);
      classified.msg       = req_data.msg;
      classified.feat      = req_data.in_feat;
      classified.last_edge = req_data.last_edge;
      stage_vld_in = (accept & keep) | (stage_vld_ff & ~moved);
      stage_in     = accept ? classified : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule
`default_nettype wire

FILE: src/csa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_div: restoring divider for the mean result
// Divides an accumulator magnitude by the row degree, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module csa_div #(
   parameter int DEG_BITS = csa_pkg::DEG_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [csa_pkg::ACC_W-1:0] dividend,
   input  wire logic [DEG_BITS:0]         divisor,
   output logic                           done,
   output logic      [csa_pkg::ACC_W-1:0] quot
);

   localparam int AW  = csa_pkg::ACC_W;
   localparam int DW  = DEG_BITS + 1;
   localparam int CNW = $clog2(AW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]  quo_ff, quo_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  dvs_ff, dvs_in;
   logic [DW:0]    trial;
   logic [DW:0]    diff;
   logic           ge;

   assign done = done_ff;
   assign quot = quo_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[AW-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(AW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[AW-2:0], ge};
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

FILE: src/csa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csa_back: reduction engine of the segment aggregator
// Reads and updates the per-feature accumulators, counts edges, closes
// features with sum, mean or max results and expands empty-row markers.
// ----------------------------------------------------------------------------
module csa_back #(
   parameter int FEATS    = csa_pkg::FEATS_DEF,
   parameter int DEG_BITS = csa_pkg::DEG_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [csa_pkg::MODE_W-1:0] mode,
   input  wire csa_pkg::work_type          work_data,
   input  wire logic                       work_empty,
   output logic                            work_pop,
   output csa_pkg::rsp_type                rsp_item,
   output logic                            rsp_push,
   input  wire logic                       rsp_full
);

   localparam int FW = (FEATS > 1) ? $clog2(FEATS) : 1;
   localparam int AW = csa_pkg::ACC_W;
   localparam int DW = csa_pkg::DATA_W;
   localparam logic [FW-1:0] LAST_FEAT = FW'(FEATS - 1);
   localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW - 1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW - 1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_CLOSE,
      ST_DIV,
      ST_OUT,
      ST_CLR
   } state_type;

   function automatic logic [DW-1:0] sat32(input logic [AW-1:0] v);
      logic [AW-DW:0] upper;
      upper = v[AW-1:DW-1];
      if (upper == '0 || upper == '1) begin
         return v[DW-1:0];
      end else if (v[AW-1]) begin
         return {1'b1, {(DW - 1){1'b0}}};
      end else begin
         return {1'b0, {(DW - 1){1'b1}}};
      end
   endfunction

   state_type          state_ff, state_in;
   logic [FEATS-1:0]   fresh_ff, fresh_in;
   logic [DEG_BITS-1:0] edge_cnt_ff, edge_cnt_in;
   logic [FW-1:0]      clr_idx_ff, clr_idx_in;

   csa_pkg::work_type  item_ff, item_in;
   logic [AW-1:0]      acc_mem [FEATS];
   logic [AW-1:0]      rd_data_ff;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [DEG_BITS:0]  deg_ff, deg_in;
   logic               neg_ff, neg_in;
   csa_pkg::rsp_type   res_ff, res_in;

   logic [FW-1:0]        idx;
   logic signed [AW-1:0] cur_acc;
   logic signed [AW-1:0] msg_ext;
   logic [AW:0]          sum_wide;
   logic signed [AW-1:0] sum_sat;
   logic signed [AW-1:0] new_acc;
   logic                 mem_wr;
   logic                 div_start;
   logic [AW-1:0]        div_dvd;
   logic                 div_done;
   logic [AW-1:0]        div_quot;
   logic [AW-1:0]        mean_val;

   csa_div #(
      .DEG_BITS (DEG_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (deg_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   always_comb begin
      idx      = item_ff.feat[FW-1:0];
      cur_acc  = rd_data_ff;
      msg_ext  = {{(AW - DW){item_ff.msg[DW-1]}}, item_ff.msg};
      sum_wide = {cur_acc[AW-1], cur_acc} + {msg_ext[AW-1], msg_ext};
      if (sum_wide[AW] != sum_wide[AW-1]) begin
         sum_sat = sum_wide[AW] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = sum_wide[AW-1:0];
      end
      if (fresh_ff[idx]) begin
         new_acc = msg_ext;
      end else if (mode == csa_pkg::MODE_MAX) begin
         new_acc = (msg_ext > cur_acc) ? msg_ext : cur_acc;
      end else begin
         new_acc = sum_sat;
      end
      div_dvd  = acc_ff[AW-1] ? -acc_ff : acc_ff;
      mean_val = neg_ff ? -div_quot : div_quot;

      state_in    = state_ff;
      fresh_in    = fresh_ff;
      edge_cnt_in = edge_cnt_ff;
      clr_idx_in  = clr_idx_ff;
      item_in     = item_ff;
      acc_in      = acc_ff;
      deg_in      = deg_ff;
      neg_in      = neg_ff;
      res_in      = res_ff;
      work_pop    = 1'b0;
      rsp_push    = 1'b0;
      rsp_item    = res_ff;
      mem_wr      = 1'b0;
      div_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!work_empty) begin
               work_pop = 1'b1;
               item_in  = work_data;
               if (work_data.clear_row) begin
                  fresh_in    = '1;
                  edge_cnt_in = '0;
                  clr_idx_in  = '0;
                  state_in    = ST_CLR;
               end else begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            mem_wr        = 1'b1;
            acc_in        = new_acc;
            deg_in        = {1'b0, edge_cnt_ff} + 1'b1;
            fresh_in[idx] = item_ff.last_edge;
            if (idx == LAST_FEAT) begin
               if (item_ff.last_edge) begin
                  edge_cnt_in = '0;
               end else if (edge_cnt_ff != '1) begin
                  edge_cnt_in = edge_cnt_ff + 1'b1;
               end
            end
            state_in = item_ff.last_edge ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            res_in.out_feat = item_ff.feat;
            res_in.row_done = (idx == LAST_FEAT);
            if (mode == csa_pkg::MODE_MEAN) begin
               div_start = 1'b1;
               neg_in    = acc_ff[AW-1];
               state_in  = ST_DIV;
            end else begin
               res_in.result = sat32(acc_ff);
               state_in      = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in.result = sat32(mean_val);
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_push = 1'b1;
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLR: begin
            rsp_push          = 1'b1;
            rsp_item.result   = '0;
            rsp_item.out_feat = csa_pkg::FEAT_W'(clr_idx_ff);
            rsp_item.row_done = (clr_idx_ff == LAST_FEAT);
            if (!rsp_full) begin
               clr_idx_in = clr_idx_ff + 1'b1;
               if (clr_idx_ff == LAST_FEAT) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fresh_ff    <= '1;
         edge_cnt_ff <= '0;
         clr_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fresh_ff    <= fresh_in;
         edge_cnt_ff <= edge_cnt_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      acc_ff  <= acc_in;
      deg_ff  <= deg_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         acc_mem[idx] <= new_acc;
      end
      if (work_pop) begin
         rd_data_ff <= acc_mem[work_data.feat[FW-1:0]];
      end
   end

endmodule
`default_nettype wire

FILE: src/csr_segment_aggregate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csr_segment_aggregate: per-row sum, mean or max of CSR edge messages
// Reduces Q16.16 edge-message elements per feature and emits one result
// for each feature closed by a row's last edge or by an empty-row marker.
// ----------------------------------------------------------------------------
//  channel   ports                         item
//  request   req_push / req_full           op, msg, in_feat, last_edge
//  response  rsp_empty / rsp_pop           result, out_feat, row_done
//  control   csr_valid / csr_ready         mode
//
//  An element passes the reduction engine as accumulator read and update;
//  a closing element adds a close and a result step, with a wait on the
//  bit-serial divider in mean mode. An empty-row marker emits a zero result
//  per feature. Reset is synchronous; no memory clearing pass is needed.
//  A 4-entry work queue lets the input side run ahead while the result side
//  stalls; the 2-entry result queue holds finished items until popped.
// ----------------------------------------------------------------------------
module csr_segment_aggregate #(
   parameter int FEATS    = csa_pkg::FEATS_DEF,
   parameter int DEG_BITS = csa_pkg::DEG_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire csa_pkg::req_type           req_data,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output csa_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [csa_pkg::MODE_W-1:0] csr_data
);

   logic [csa_pkg::MODE_W-1:0] mode_ff, mode_in;

   logic               work_push, work_full, work_pop, work_empty;
   csa_pkg::work_type  work_in_data, work_out_data;
   logic               rsp_push, rsp_full;
   csa_pkg::rsp_type   rsp_item;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid & csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csa_pkg::MODE_SUM;
      end else begin
         mode_ff <= mode_in;
      end
   end

   csa_front #(
      .FEATS (FEATS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .work_push (work_push),
      .work_data (work_in_data),
      .work_full (work_full)
   );

   csa_fifo #(
      .WIDTH ($bits(csa_pkg::work_type)),
      .DEPTH (csa_pkg::WORK_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in_data),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_out_data),
      .empty     (work_empty)
   );

   csa_back #(
      .FEATS    (FEATS),
      .DEG_BITS (DEG_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .work_data  (work_out_data),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .rsp_item   (rsp_item),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_full)
   );

   csa_fifo #(
      .WIDTH ($bits(csa_pkg::rsp_type)),
      .DEPTH (csa_pkg::RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
`default_nettype wire

FILE: bench/tb_csr_segment_aggregate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csr_segment_aggregate: self-checking bench for the CSR segment aggregator
// Streams edge-message elements and empty-row markers through the queue-style
// ports, with random gaps on both sides. A behavioral copy of the per-feature
// sum, mean and max reduction predicts each result, and each popped result is
// compared field by field in order.
// ----------------------------------------------------------------------------
module tb_csr_segment_aggregate;

   localparam int FEATS      = csa_pkg::FEATS_DEF;
   localparam int DEG_BITS   = csa_pkg::DEG_BITS_DEF;
   localparam int DEG_MAX    = (1 << DEG_BITS) - 1;
   localparam int DEEP_EDGES = 5;
   localparam int SETTLE     = 64;

   localparam logic [csa_pkg::MODE_W-1:0] MODE_ALT_SUM = 2'd3;

   localparam longint ACC_HI = 64'sd140737488355327;
   localparam longint ACC_LO = -ACC_HI - 64'sd1;
   localparam longint OUT_HI = 64'sd2147483647;
   localparam longint OUT_LO = -64'sd2147483648;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   csa_pkg::req_type           req_data;
   logic                       req_full;
   logic                       rsp_empty;
   logic                       rsp_pop;
   csa_pkg::rsp_type           rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [csa_pkg::MODE_W-1:0] csr_data;

   longint                     feat_acc [FEATS];
   bit                         feat_fresh [FEATS];
   int                         edge_cnt;
   logic [csa_pkg::MODE_W-1:0] agg_mode;
   csa_pkg::rsp_type           pending_results [$];
   int                         mismatch_count = 0;
   bit                         gaps_on = 1'b1;
   bit                         stalls_on = 1'b1;
   int                         stall_left = 0;

   csr_segment_aggregate #(
      .FEATS    (FEATS),
      .DEG_BITS (DEG_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic clear_rows();
      for (int f = 0; f < FEATS; f++) begin
         feat_acc[f]   = 0;
         feat_fresh[f] = 1'b1;
      end
      edge_cnt = 0;
   endtask

   task automatic reduce_item(input csa_pkg::req_type it);
      longint           v;
      longint           r;
      int               f;
      csa_pkg::rsp_type want;
      if (it.op == csa_pkg::OP_EMPTY) begin
         for (int k = 0; k < FEATS; k++) begin
            want.result   = '0;
            want.out_feat = k[csa_pkg::FEAT_W-1:0];
            want.row_done = (k == FEATS - 1);
            pending_results.push_back(want);
         end
         clear_rows();
         return;
      end
      if (int'(it.in_feat) >= FEATS) return;
      f = int'(it.in_feat);
      v = longint'($signed(it.msg));
      if (feat_fresh[f]) begin
         feat_acc[f]   = v;
         feat_fresh[f] = 1'b0;
      end else if (agg_mode == csa_pkg::MODE_MAX) begin
         if (v > feat_acc[f]) feat_acc[f] = v;
      end else begin
         r = feat_acc[f] + v;
         if (r > ACC_HI) r = ACC_HI;
         if (r < ACC_LO) r = ACC_LO;
         feat_acc[f] = r;
      end
      if (!it.last_edge) begin
         if (f == FEATS - 1 && edge_cnt < DEG_MAX) edge_cnt++;
         return;
      end
      r = feat_acc[f];
      if (agg_mode == csa_pkg::MODE_MEAN) r = r / longint'(edge_cnt + 1);
      if (r > OUT_HI) r = OUT_HI;
      if (r < OUT_LO) r = OUT_LO;
      want.result   = r[csa_pkg::DATA_W-1:0];
      want.out_feat = it.in_feat;
      want.row_done = (f == FEATS - 1);
      pending_results.push_back(want);
      feat_acc[f]   = 0;
      feat_fresh[f] = 1'b1;
      if (f == FEATS - 1) edge_cnt = 0;
   endtask

   function automatic csa_pkg::req_type make_item(input logic op,
                                                  input logic [csa_pkg::DATA_W-1:0] msg,
                                                  input int feat, input logic last);
      csa_pkg::req_type it;
      it.op        = op;
      it.msg       = msg;
      it.in_feat   = feat[csa_pkg::FEAT_W-1:0];
      it.last_edge = last;
      return it;
   endfunction

   function automatic logic [csa_pkg::DATA_W-1:0] rand_msg();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return csa_pkg::DATA_W'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input csa_pkg::req_type it);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      reduce_item(it);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic [csa_pkg::MODE_W-1:0] m);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      agg_mode = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_pop    <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_pop    <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      csa_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, got result %0d feat %0d row_done %0b",
                     $time, rsp_data.result, rsp_data.out_feat, rsp_data.row_done);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result !== want.result) begin
               $display("%0t: result mismatch, expected %0d, got %0d",
                        $time, want.result, rsp_data.result);
               mismatch_count++;
            end
            if (rsp_data.out_feat !== want.out_feat) begin
               $display("%0t: out_feat mismatch, expected %0d, got %0d",
                        $time, want.out_feat, rsp_data.out_feat);
               mismatch_count++;
            end
            if (rsp_data.row_done !== want.row_done) begin
               $display("%0t: row_done mismatch, expected %0b, got %0b",
                        $time, want.row_done, rsp_data.row_done);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_sum_extremes();
      send_item(make_item(csa_pkg::OP_ELEM, 32'h7FFF_FFFF, 0, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h7FFF_FFFF, 0, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h8000_0000, 1, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h8000_0000, 1, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h0000_0000, 2, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, 32'hFFFF_FFFF, 3, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, $urandom, 63, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, $urandom, FEATS, 1'b0));
   endtask

   task automatic test_mean_truncation();
      write_mode(csa_pkg::MODE_MEAN);
      send_item(make_item(csa_pkg::OP_ELEM, 32'd5, FEATS - 1, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, -32'sd7, 3, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, 32'd0, 3, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, 32'd4, FEATS - 1, 1'b1));
   endtask

   task automatic test_max_mode();
      write_mode(csa_pkg::MODE_MAX);
      send_item(make_item(csa_pkg::OP_ELEM, -32'sd5, 4, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, -32'sd9, 4, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, -32'sd2, 4, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h8000_0000, 5, 1'b1));
   endtask

   task automatic test_mode_three();
      write_mode(MODE_ALT_SUM);
      send_item(make_item(csa_pkg::OP_ELEM, 32'd1, 6, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, 32'd2, 6, 1'b1));
   endtask

   task automatic test_mode_switch_in_row();
      write_mode(csa_pkg::MODE_SUM);
      send_item(make_item(csa_pkg::OP_ELEM, 32'd10, 0, 1'b0));
      write_mode(csa_pkg::MODE_MAX);
      send_item(make_item(csa_pkg::OP_ELEM, 32'd3, 0, 1'b1));
   endtask

   task automatic test_empty_row();
      send_item(make_item(csa_pkg::OP_ELEM, 32'd100, 2, 1'b0));
      send_item(make_item(csa_pkg::OP_EMPTY, $urandom, $urandom_range(0, 63),
                          1'($urandom)));
      send_item(make_item(csa_pkg::OP_ELEM, 32'd1, 2, 1'b1));
   endtask

   task automatic test_mean_degree();
      write_mode(csa_pkg::MODE_MEAN);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      for (int i = 0; i < DEEP_EDGES; i++) begin
         send_item(make_item(csa_pkg::OP_ELEM, 32'h7FFF_FFFF, 0, 1'b0));
         send_item(make_item(csa_pkg::OP_ELEM, 32'h0001_0000, FEATS - 1, 1'b0));
      end
      repeat (4) send_item(make_item(csa_pkg::OP_ELEM, 32'h8000_0000, 0, 1'b0));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h8000_0000, 0, 1'b1));
      send_item(make_item(csa_pkg::OP_ELEM, 32'h0001_0000, FEATS - 1, 1'b1));
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_random_rows(input int count, input bit idle);
      int sent;
      int next_cfg;
      int pick;
      int deg;
      int cut;
      sent     = 0;
      next_cfg = 0;
      while (sent < count) begin
         if (sent >= next_cfg) begin
            write_mode(csa_pkg::MODE_W'($urandom_range(0, 3)));
            next_cfg = sent + $urandom_range(20, 40);
         end
         gaps_on   = idle && ($urandom_range(0, 3) != 0);
         stalls_on = idle && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_item(make_item(csa_pkg::OP_EMPTY, $urandom, $urandom_range(0, 63),
                                1'($urandom)));
            sent++;
         end else if (pick == 1) begin
            send_item(make_item(csa_pkg::OP_ELEM, $urandom, $urandom_range(FEATS, 63),
                                1'($urandom)));
         end else begin
            deg = $urandom_range(1, 3);
            cut = (pick == 2) ? $urandom_range(1, deg * FEATS - 1) : deg * FEATS;
            for (int k = 0; k < cut; k++) begin
               send_item(make_item(csa_pkg::OP_ELEM, rand_msg(), k % FEATS,
                                   (k / FEATS) == deg - 1));
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      agg_mode  = csa_pkg::MODE_SUM;
      clear_rows();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_sum_extremes();
      test_mean_truncation();
      test_max_mode();
      test_mode_three();
      test_mode_switch_in_row();
      test_empty_row();
      test_mean_degree();
      test_random_rows(40, 1'b1);
      test_random_rows(15, 1'b0);

      drain_results();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/csa_pkg.sv
src/csa_fifo.sv
src/csa_front.sv
src/csa_div.sv
src/csa_back.sv
src/csr_segment_aggregate.sv
bench/tb_csr_segment_aggregate.sv
